@@ sv/lcsnq_pkg.sv @@
// ----------------------------------------------------------------------------
// lcsnq_pkg: shared types and constants
// Request codes, probe slots and the command word that travels from the
// request decoder to the cell table.
// ----------------------------------------------------------------------------
package lcsnq_pkg;

   localparam int CELL_BITS = 14;
   localparam int CELL_MIN  = -8192;
   localparam int CELL_MAX  = 8191;

   localparam int REQ_BITS       = 2;
   localparam int DIR_BITS       = 4;
   localparam int DIR_COUNT_BITS = 3;

   // Floor divider remainder width
   localparam int REM_BITS = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Probe slots: self cell, then east, north, west, south neighbor
   localparam int NUM_PROBES  = 5;
   localparam int PROBE_SELF  = 0;
   localparam int PROBE_EAST  = 1;
   localparam int PROBE_NORTH = 2;
   localparam int PROBE_WEST  = 3;
   localparam int PROBE_SOUTH = 4;

   typedef enum logic [REQ_BITS-1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type                            kind;
      logic [NUM_PROBES-1:0][CELL_BITS-1:0]    key_x;
      logic [NUM_PROBES-1:0][CELL_BITS-1:0]    key_z;
      logic [NUM_PROBES-1:0]                   key_ok;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

@@ sv/lcsnq_ifs.sv @@
// ----------------------------------------------------------------------------
// lcsnq channel interfaces
// Valid/ready channels for requests and responses of the loaded cell set.
// ----------------------------------------------------------------------------
interface lcsnq_req_if #(
   parameter int INDEX_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic signed [13:0]           cell_x;
   logic signed [13:0]           cell_z;
   logic signed [INDEX_BITS-1:0] inter_i;
   logic signed [INDEX_BITS-1:0] inter_j;

   modport source (output valid, req_type, cell_x, cell_z, inter_i, inter_j,
                   input ready);
   modport sink   (input valid, req_type, cell_x, cell_z, inter_i, inter_j,
                   output ready);
endinterface

interface lcsnq_rsp_if #(
   parameter int TOTAL_BITS = 7
);
   logic                  valid;
   logic                  ready;
   logic                  self_loaded;
   logic [3:0]            dir_mask;
   logic [2:0]            dir_count;
   logic [TOTAL_BITS-1:0] cell_total;
   logic                  table_full;

   modport source (output valid, self_loaded, dir_mask, dir_count, cell_total,
                   table_full, input ready);
   modport sink   (input valid, self_loaded, dir_mask, dir_count, cell_total,
                   table_full, output ready);
endinterface

@@ sv/lcsnq_queue.sv @@
// ----------------------------------------------------------------------------
// lcsnq_queue: command queue
// Short FIFO that decouples the request decoder from the cell table.
// ----------------------------------------------------------------------------
module lcsnq_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lcsnq_pkg::cmd_type          push_cmd,
   input  logic                        pop,
   output lcsnq_pkg::cmd_type          head_cmd,
   output lcsnq_pkg::queue_status_type status
);
   import lcsnq_pkg::*;

   cmd_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));

endmodule

@@ sv/lcsnq_front.sv @@
// ----------------------------------------------------------------------------
// lcsnq_front: request decoder
// Accepts requests, maps query intersections to cells by floor division
// by the cell span, builds the five probe keys and pushes commands.
// ----------------------------------------------------------------------------
module lcsnq_front #(
   parameter int CELL_SPAN  = 4,
   parameter int INDEX_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   lcsnq_req_if.sink                   req_ch,
   output logic                        push_valid,
   output lcsnq_pkg::cmd_type          push_cmd,
   input  lcsnq_pkg::queue_status_type q_status
);
   import lcsnq_pkg::*;

   // Offset index is non-negative and below 17 * 2^(INDEX_BITS-1)
   localparam int DW       = INDEX_BITS + 4;
   localparam int SPAN_LOG = $clog2(CELL_SPAN);
   localparam int MW       = DW + 1;
   localparam int PRW      = DW + MW;
   localparam int QW = (INDEX_BITS + 1 > CELL_BITS + 1) ? INDEX_BITS + 1 : CELL_BITS + 1;

   // Rounded-up reciprocal of the span: the product shifted right by
   // DW + SPAN_LOG is the exact floor quotient of any DW-bit dividend
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << (DW + SPAN_LOG)) + 64'(CELL_SPAN) - 64'd1) / 64'(CELL_SPAN);
   localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);

   localparam logic [DW-1:0]       DIV_OFFSET = DW'(CELL_SPAN) << (INDEX_BITS - 1);
   localparam logic [REM_BITS-1:0] SPAN_R     = REM_BITS'(CELL_SPAN);
   localparam logic [REM_BITS-1:0] SPAN_LAST  = REM_BITS'(CELL_SPAN - 1);
   localparam logic signed [QW-1:0] KEY_MIN   = QW'(CELL_MIN);
   localparam logic signed [QW-1:0] KEY_MAX   = QW'(CELL_MAX);

   typedef enum logic [2:0] {
      FR_IDLE = 3'b001,
      FR_DIV  = 3'b010,
      FR_PUSH = 3'b100
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic [DW-1:0]         num_i_ff, num_i_in;
   logic [DW-1:0]         num_j_ff, num_j_in;
   logic [INDEX_BITS-1:0] quo_i_ff, quo_i_in;
   logic [INDEX_BITS-1:0] quo_j_ff, quo_j_in;

   logic                  req_fire;
   req_kind_type          req_kind;
   logic [DW-1:0]         off_i, off_j;
   logic [PRW-1:0]        prod_i, prod_j;
   logic [REM_BITS-1:0]   span_i, span_j, rem_i, rem_j;
   logic [INDEX_BITS-1:0] ctr_i_raw, ctr_j_raw;
   logic signed [QW-1:0]  ctr_x, ctr_z, east_x, west_x, north_z, south_z;
   cmd_type               query_cmd, direct_cmd;

   function automatic logic key_in_range(input logic signed [QW-1:0] v);
      return (v >= KEY_MIN) && (v <= KEY_MAX);
   endfunction

   assign req_kind     = req_kind_type'(req_ch.req_type);
   assign req_ch.ready = (state_ff == FR_IDLE) && !q_status.full;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign off_i = {{4{req_ch.inter_i[INDEX_BITS-1]}}, req_ch.inter_i} + DIV_OFFSET;
   assign off_j = {{4{req_ch.inter_j[INDEX_BITS-1]}}, req_ch.inter_j} + DIV_OFFSET;

   assign prod_i = PRW'(num_i_ff) * PRW'(RECIP);
   assign prod_j = PRW'(num_j_ff) * PRW'(RECIP);

   always_comb begin
      state_in = state_ff;
      num_i_in = num_i_ff;
      num_j_in = num_j_ff;
      quo_i_in = quo_i_ff;
      quo_j_in = quo_j_ff;
      case (state_ff)
         FR_IDLE: begin
            if (req_fire && req_kind == REQ_QUERY) begin
               num_i_in = off_i;
               num_j_in = off_j;
               state_in = FR_DIV;
            end
         end
         FR_DIV: begin
            // Drop the fraction bits of the reciprocal product
            quo_i_in = prod_i[DW+SPAN_LOG +: INDEX_BITS];
            quo_j_in = prod_j[DW+SPAN_LOG +: INDEX_BITS];
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            if (!q_status.full) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_i_ff <= num_i_in;
      num_j_ff <= num_j_in;
      quo_i_ff <= quo_i_in;
      quo_j_ff <= quo_j_in;
   end

   // The remainder is below the span, so its low bits alone recover it
   assign span_i = quo_i_ff[REM_BITS-1:0] * SPAN_R;
   assign span_j = quo_j_ff[REM_BITS-1:0] * SPAN_R;
   assign rem_i  = num_i_ff[REM_BITS-1:0] - span_i;
   assign rem_j  = num_j_ff[REM_BITS-1:0] - span_j;

   // Remove the offset bias: flipping the top quotient bit yields the signed cell
   assign ctr_i_raw = {~quo_i_ff[INDEX_BITS-1], quo_i_ff[INDEX_BITS-2:0]};
   assign ctr_j_raw = {~quo_j_ff[INDEX_BITS-1], quo_j_ff[INDEX_BITS-2:0]};
   assign ctr_x = {{(QW-INDEX_BITS){ctr_i_raw[INDEX_BITS-1]}}, ctr_i_raw};
   assign ctr_z = {{(QW-INDEX_BITS){ctr_j_raw[INDEX_BITS-1]}}, ctr_j_raw};

   // A neighbor leaves the cell only from its last or first row of the span
   assign east_x  = ctr_x + QW'(rem_i == SPAN_LAST);
   assign west_x  = ctr_x - QW'(rem_i == '0);
   assign north_z = ctr_z + QW'(rem_j == SPAN_LAST);
   assign south_z = ctr_z - QW'(rem_j == '0);

   always_comb begin
      query_cmd.kind = REQ_QUERY;
      query_cmd.key_x[PROBE_SELF]  = ctr_x[CELL_BITS-1:0];
      query_cmd.key_z[PROBE_SELF]  = ctr_z[CELL_BITS-1:0];
      query_cmd.key_x[PROBE_EAST]  = east_x[CELL_BITS-1:0];
      query_cmd.key_z[PROBE_EAST]  = ctr_z[CELL_BITS-1:0];
      query_cmd.key_x[PROBE_NORTH] = ctr_x[CELL_BITS-1:0];
      query_cmd.key_z[PROBE_NORTH] = north_z[CELL_BITS-1:0];
      query_cmd.key_x[PROBE_WEST]  = west_x[CELL_BITS-1:0];
      query_cmd.key_z[PROBE_WEST]  = ctr_z[CELL_BITS-1:0];
      query_cmd.key_x[PROBE_SOUTH] = ctr_x[CELL_BITS-1:0];
      query_cmd.key_z[PROBE_SOUTH] = south_z[CELL_BITS-1:0];
      query_cmd.key_ok[PROBE_SELF]  = key_in_range(ctr_x) && key_in_range(ctr_z);
      query_cmd.key_ok[PROBE_EAST]  = key_in_range(east_x) && key_in_range(ctr_z);
      query_cmd.key_ok[PROBE_NORTH] = key_in_range(ctr_x) && key_in_range(north_z);
      query_cmd.key_ok[PROBE_WEST]  = key_in_range(west_x) && key_in_range(ctr_z);
      query_cmd.key_ok[PROBE_SOUTH] = key_in_range(ctr_x) && key_in_range(south_z);
   end

   always_comb begin
      direct_cmd        = '0;
      direct_cmd.kind   = req_kind;
      direct_cmd.key_x[PROBE_SELF]  = req_ch.cell_x;
      direct_cmd.key_z[PROBE_SELF]  = req_ch.cell_z;
      direct_cmd.key_ok[PROBE_SELF] = 1'b1;
   end

   always_comb begin
      push_valid = 1'b0;
      push_cmd   = direct_cmd;
      case (state_ff)
         FR_IDLE: begin
            push_valid = req_fire && (req_kind != REQ_QUERY);
         end
         FR_PUSH: begin
            push_valid = !q_status.full;
            push_cmd   = query_cmd;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/lcsnq_back.sv @@
// ----------------------------------------------------------------------------
// lcsnq_back: cell table
// Content-addressed table of loaded cells. Unless the response stalls, it
// executes one command per cycle with a parallel match of all probe keys and drives the response register.
// ----------------------------------------------------------------------------
module lcsnq_back #(
   parameter int TABLE_DEPTH = 64,
   parameter int TOTAL_BITS  = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lcsnq_pkg::cmd_type          cmd,
   input  lcsnq_pkg::queue_status_type q_status,
   output logic                        cmd_pop,
   lcsnq_rsp_if.source                 rsp_ch
);
   import lcsnq_pkg::*;

   logic [CELL_BITS-1:0]   entry_x_ff [TABLE_DEPTH];
   logic [CELL_BITS-1:0]   entry_z_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   self_ff, self_in;
   logic [DIR_BITS-1:0]    mask_ff, mask_in;
   logic [DIR_COUNT_BITS-1:0] count_ff, count_in;
   logic [TOTAL_BITS-1:0]  total_out_ff;
   logic                   full_ff, full_in;

   logic [NUM_PROBES-1:0][TABLE_DEPTH-1:0] match_vec;
   logic [NUM_PROBES-1:0]  hit;
   logic [TABLE_DEPTH-1:0] free_vec, free_oh;
   logic                   table_is_full;
   logic                   do_insert;

   always_comb begin
      for (int n = 0; n < NUM_PROBES; n++) begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            match_vec[n][k] = valid_ff[k] && (entry_x_ff[k] == cmd.key_x[n])
                              && (entry_z_ff[k] == cmd.key_z[n]);
         end
         hit[n] = (|match_vec[n]) && cmd.key_ok[n];
      end
   end

   // Lowest free entry as a one-hot vector
   assign free_vec      = ~valid_ff;
   assign free_oh       = free_vec & (~free_vec + TABLE_DEPTH'(1));
   assign table_is_full = &valid_ff;

   assign cmd_pop   = !q_status.empty && (!rsp_valid_ff || rsp_ch.ready);
   assign do_insert = cmd_pop && (cmd.kind == REQ_ADD) && !hit[PROBE_SELF] && !table_is_full;

   always_comb begin
      valid_in     = valid_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      self_in      = 1'b0;
      mask_in      = '0;
      count_in     = '0;
      full_in      = 1'b0;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
         case (cmd.kind)
            REQ_ADD: begin
               if (!hit[PROBE_SELF]) begin
                  if (table_is_full) begin
                     full_in = 1'b1;
                  end else begin
                     valid_in = valid_ff | free_oh;
                     total_in = total_ff + TOTAL_BITS'(1);
                  end
               end
            end
            REQ_REMOVE: begin
               if (hit[PROBE_SELF]) begin
                  valid_in = valid_ff & ~match_vec[PROBE_SELF];
                  total_in = total_ff - TOTAL_BITS'(1);
               end
            end
            REQ_QUERY: begin
               self_in  = hit[PROBE_SELF];
               mask_in  = {hit[PROBE_SOUTH], hit[PROBE_WEST], hit[PROBE_NORTH],
                           hit[PROBE_EAST]};
               count_in = DIR_COUNT_BITS'($countones(mask_in));
            end
            default: begin
               self_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload until a new command executes
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         self_ff      <= self_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         total_out_ff <= total_in;
         full_ff      <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (do_insert && free_oh[k]) begin
            entry_x_ff[k] <= cmd.key_x[PROBE_SELF];
            entry_z_ff[k] <= cmd.key_z[PROBE_SELF];
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.self_loaded = self_ff;
   assign rsp_ch.dir_mask    = mask_ff;
   assign rsp_ch.dir_count   = count_ff;
   assign rsp_ch.cell_total  = total_out_ff;
   assign rsp_ch.table_full  = full_ff;

endmodule

@@ sv/loaded_cell_set_neighbor_query.sv @@
// ----------------------------------------------------------------------------
// loaded_cell_set_neighbor_query: loaded cell set with neighbor query
//
//   channel   direction   handshake      payload
//   req_ch    in          valid/ready    req_type, cell_x, cell_z, inter_i, inter_j
//   rsp_ch    out         valid/ready    self_loaded, dir_mask, dir_count,
//                                        cell_total, table_full
//
// Add, remove and unused requests are pushed in the cycle they are accepted; a
// query is accepted, then takes a reciprocal multiply for the floor division by
// the cell span, then the push of its five probe keys, and blocks new requests
// until pushed. Unless the response stalls, the cell table executes one command
// per cycle; each command passes the command queue and the response register,
// a query first the divide and push states. Synchronous reset clears the valid
// bits and the cell count. A stalled response holds the table; the two-entry
// command queue keeps the decoder accepting until it fills.
// ----------------------------------------------------------------------------
module loaded_cell_set_neighbor_query #(
   parameter int TABLE_DEPTH = 64,
   parameter int CELL_SPAN   = 4,
   parameter int INDEX_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   lcsnq_req_if.sink   req_ch,
   lcsnq_rsp_if.source rsp_ch
);
   import lcsnq_pkg::*;

   localparam int TOTAL_BITS = $clog2(TABLE_DEPTH + 1);

   logic             push_valid;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             cmd_pop;
   queue_status_type q_status;

   lcsnq_front #(
      .CELL_SPAN  (CELL_SPAN),
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_status   (q_status)
   );

   lcsnq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   lcsnq_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TOTAL_BITS  (TOTAL_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (head_cmd),
      .q_status (q_status),
      .cmd_pop  (cmd_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ verif/loaded_cell_set_neighbor_query_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// loaded_cell_set_neighbor_query_test: testbench for the loaded cell set
// Drives add, remove, query and unused requests through the request channel.
// A shadow copy of the cell table predicts every response, and a checker
// compares each response transfer field by field. Stimulus covers the
// coordinate extremes, a full table, a long response stall and random traffic.
// ----------------------------------------------------------------------------
module loaded_cell_set_neighbor_query_test;
   import lcsnq_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int CELL_SPAN    = 4;
   localparam int INDEX_BITS   = 16;
   localparam int TOTAL_BITS   = 7;
   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_CYCLES  = 80;
   localparam int RANDOM_ITEMS = 340;
   localparam int PRINT_LIMIT  = 30;

   typedef struct packed {
      logic                  self_loaded;
      logic [3:0]            dir_mask;
      logic [2:0]            dir_count;
      logic [TOTAL_BITS-1:0] cell_total;
      logic                  table_full;
   } cell_answer_type;

   logic clock;
   logic reset;

   lcsnq_req_if #(.INDEX_BITS(INDEX_BITS)) req_bus ();
   lcsnq_rsp_if #(.TOTAL_BITS(TOTAL_BITS)) rsp_bus ();

   loaded_cell_set_neighbor_query #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_SPAN   (CELL_SPAN),
      .INDEX_BITS  (INDEX_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // shadow copy of the cell table
   logic signed [CELL_BITS-1:0] shadow_x [TABLE_DEPTH];
   logic signed [CELL_BITS-1:0] shadow_z [TABLE_DEPTH];
   bit                          shadow_used [TABLE_DEPTH];
   int                          shadow_count = 0;

   cell_answer_type answers_due [$];

   int error_count  = 0;
   int idle_cycles  = 0;
   int hold_left    = 0;
   bit hold_request = 0;
   bit send_gaps    = 1;
   bit take_gaps    = 1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < PRINT_LIMIT)
         $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic int floor_span(int v);
      int q;
      q = v / CELL_SPAN;
      if ((v % CELL_SPAN) != 0 && v < 0)
         q = q - 1;
      return q;
   endfunction

   function automatic int find_shadow(int x, int z);
      int sx;
      int sz;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         sx = shadow_x[k];
         sz = shadow_z[k];
         if (shadow_used[k] && sx == x && sz == z)
            return k;
      end
      return -1;
   endfunction

   function automatic bit inter_loaded(int i, int j);
      return find_shadow(floor_span(i), floor_span(j)) >= 0;
   endfunction

   // Update the shadow table and return the response this request must give
   function automatic cell_answer_type apply_cell_request(req_kind_type kind,
                                                          logic signed [CELL_BITS-1:0] cx,
                                                          logic signed [CELL_BITS-1:0] cz,
                                                          logic signed [INDEX_BITS-1:0] ii,
                                                          logic signed [INDEX_BITS-1:0] jj);
      cell_answer_type answer;
      int              slot;
      int              fi;
      int              fj;
      answer = '0;
      fi = ii;
      fj = jj;
      case (kind)
         REQ_ADD: begin
            if (find_shadow(cx, cz) < 0) begin
               slot = -1;
               for (int k = 0; k < TABLE_DEPTH; k++)
                  if (!shadow_used[k] && slot < 0)
                     slot = k;
               if (slot < 0) begin
                  answer.table_full = 1'b1;
               end else begin
                  shadow_x[slot]    = cx;
                  shadow_z[slot]    = cz;
                  shadow_used[slot] = 1'b1;
                  shadow_count++;
               end
            end
         end
         REQ_REMOVE: begin
            slot = find_shadow(cx, cz);
            if (slot >= 0) begin
               shadow_used[slot] = 1'b0;
               shadow_count--;
            end
         end
         REQ_QUERY: begin
            answer.self_loaded = inter_loaded(fi, fj);
            answer.dir_mask[0] = inter_loaded(fi + 1, fj);
            answer.dir_mask[1] = inter_loaded(fi, fj + 1);
            answer.dir_mask[2] = inter_loaded(fi - 1, fj);
            answer.dir_mask[3] = inter_loaded(fi, fj - 1);
            answer.dir_count   = answer.dir_mask[0] + answer.dir_mask[1] +
                                 answer.dir_mask[2] + answer.dir_mask[3];
         end
         default: ;
      endcase
      answer.cell_total = TOTAL_BITS'(shadow_count);
      return answer;
   endfunction

   // Offer one request and wait for its transfer
   task automatic send_item(req_kind_type kind, int cx, int cz, int ii, int jj);
      if (send_gaps && $urandom_range(99) < 30) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.cell_x   <= cx[CELL_BITS-1:0];
      req_bus.cell_z   <= cz[CELL_BITS-1:0];
      req_bus.inter_i  <= ii[INDEX_BITS-1:0];
      req_bus.inter_j  <= jj[INDEX_BITS-1:0];
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      answers_due.push_back(apply_cell_request(kind, cx[CELL_BITS-1:0], cz[CELL_BITS-1:0],
                                               ii[INDEX_BITS-1:0], jj[INDEX_BITS-1:0]));
   endtask

   task automatic drain_responses(int settle);
      req_bus.valid <= 1'b0;
      while (answers_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Well-formed requests cluster on a small patch of cells or near a
   // corner of the coordinate range; the rest is noise on every field.
   task automatic send_random_item();
      int           pick;
      int           zone;
      int           base;
      int           cx;
      int           cz;
      req_kind_type kind;
      if ($urandom_range(99) < 20) begin
         send_item(req_kind_type'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
      end else begin
         pick = $urandom_range(99);
         if (pick < 35)
            kind = REQ_ADD;
         else if (pick < 60)
            kind = REQ_REMOVE;
         else if (pick < 95)
            kind = REQ_QUERY;
         else
            kind = REQ_NONE;
         zone = $urandom_range(9);
         if (zone == 0) begin
            base = CELL_MAX - 3;
            cx = base + $urandom_range(3);
            cz = base + $urandom_range(3);
         end else if (zone == 1) begin
            base = CELL_MIN;
            cx = base + $urandom_range(3);
            cz = base + $urandom_range(3);
         end else begin
            base = -4;
            cx = base + $urandom_range(7);
            cz = base + $urandom_range(7);
         end
         if (kind == REQ_QUERY)
            send_item(kind, $urandom, $urandom,
                      cx * CELL_SPAN + $urandom_range(CELL_SPAN + 1) - 1,
                      cz * CELL_SPAN + $urandom_range(CELL_SPAN + 1) - 1);
         else
            send_item(kind, cx, cz, $urandom, $urandom);
      end
   endtask

   task automatic test_directed_cases();
      send_item(REQ_QUERY, 0, 0, 0, 0);
      send_item(REQ_ADD, 0, 0, 0, 0);
      send_item(REQ_ADD, 0, 0, -1, -1);
      send_item(REQ_ADD, 1, 0, 0, 0);
      send_item(REQ_ADD, 0, -1, 0, 0);
      send_item(REQ_ADD, CELL_MAX, CELL_MAX, -1, -1);
      send_item(REQ_ADD, CELL_MIN, CELL_MIN, 0, 0);
      send_item(REQ_ADD, CELL_MAX, CELL_MIN, 0, 0);
      send_item(REQ_QUERY, 0, 0, 3, 0);
      send_item(REQ_QUERY, 0, 0, 0, 0);
      send_item(REQ_QUERY, -1, -1, 4, 3);
      // neighbors past the cell range are never loaded
      send_item(REQ_QUERY, 0, 0, 32767, 32767);
      send_item(REQ_QUERY, 0, 0, -32768, -32768);
      send_item(REQ_QUERY, 0, 0, 32767, -32768);
      send_item(REQ_QUERY, CELL_MAX, CELL_MIN, -5, 2);
      send_item(REQ_NONE, CELL_MAX, CELL_MAX, 32767, 32767);
      send_item(REQ_REMOVE, 5, 5, 0, 0);
      send_item(REQ_REMOVE, 0, 0, 0, 0);
      send_item(REQ_QUERY, 0, 0, 1, 1);
      send_item(REQ_REMOVE, CELL_MIN, CELL_MIN, 0, 0);
      send_item(REQ_QUERY, 0, 0, -32768, -32768);
      drain_responses(4);
   endtask

   task automatic test_table_full();
      for (int k = 0; k < TABLE_DEPTH + 3; k++)
         send_item(REQ_ADD, k - 32, 77, $urandom, $urandom);
      // duplicate on a full table is not refused
      send_item(REQ_ADD, 0, 77, 0, 0);
      send_item(REQ_QUERY, 0, 0, -4, 308);
      send_item(REQ_REMOVE, -27, 77, 0, 0);
      send_item(REQ_REMOVE, -22, 77, 0, 0);
      send_item(REQ_ADD, 1000, 1000, 0, 0);
      send_item(REQ_ADD, 1001, 1001, 0, 0);
      send_item(REQ_ADD, 1002, 1002, 0, 0);
      send_item(REQ_QUERY, 0, 0, 4003, 4003);
      for (int k = 0; k < TABLE_DEPTH + 3; k++)
         send_item(REQ_REMOVE, k - 32, 77, $urandom, $urandom);
      send_item(REQ_REMOVE, 1000, 1000, 0, 0);
      send_item(REQ_REMOVE, 1001, 1001, 0, 0);
      send_item(REQ_QUERY, 0, 0, 4, 0);
      drain_responses(4);
   endtask

   task automatic test_backpressure();
      send_gaps    = 0;
      hold_request = 1;
      for (int k = 0; k < 40; k++)
         send_random_item();
      send_gaps = 1;
      drain_responses(4);
   endtask

   task automatic test_random_traffic();
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         send_gaps = !(k >= 120 && k < 250);
         take_gaps = send_gaps;
         send_random_item();
      end
      send_gaps = 1;
      take_gaps = 1;
   endtask

   // response side: random stalls, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (take_gaps && $urandom_range(99) < 30) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cell_answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (answers_due.size() == 0) begin
            report_mismatch("unexpected response", rsp_bus.cell_total, 0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_bus.self_loaded !== want.self_loaded)
               report_mismatch("self_loaded", rsp_bus.self_loaded, want.self_loaded);
            if (rsp_bus.dir_mask !== want.dir_mask)
               report_mismatch("dir_mask", rsp_bus.dir_mask, want.dir_mask);
            if (rsp_bus.dir_count !== want.dir_count)
               report_mismatch("dir_count", rsp_bus.dir_count, want.dir_count);
            if (rsp_bus.cell_total !== want.cell_total)
               report_mismatch("cell_total", rsp_bus.cell_total, want.cell_total);
            if (rsp_bus.table_full !== want.table_full)
               report_mismatch("table_full", rsp_bus.table_full, want.table_full);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_NONE;
      req_bus.cell_x   <= '0;
      req_bus.cell_z   <= '0;
      req_bus.inter_i  <= '0;
      req_bus.inter_j  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_table_full();
      test_backpressure();
      test_random_traffic();

      drain_responses(10);
      if (answers_due.size() != 0)
         report_mismatch("responses missing", 0, answers_due.size());
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/lcsnq_pkg.sv
sv/lcsnq_ifs.sv
sv/lcsnq_queue.sv
sv/lcsnq_front.sv
sv/lcsnq_back.sv
sv/loaded_cell_set_neighbor_query.sv
verif/loaded_cell_set_neighbor_query_test.sv
